FILE: hdl/bumper_on_delay_stuck_detect_assert.svh
// Assertion macros used by the bumper qualifier core module.
`ifndef BUMPER_ON_DELAY_STUCK_DETECT_ASSERT_SVH
`define BUMPER_ON_DELAY_STUCK_DETECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BODSD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bumper qualifier: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BODSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bumper qualifier: next-cycle check failed");

`else

`define BODSD_ASSERT_SAME(label, ante, cons)
`define BODSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/bodsd_pkg.sv
// Package with the constants and types of the bumper qualifier.
package bodsd_pkg;

   // Width of the timestamp arithmetic; timestamps wrap modulo 2^TIME_WIDTH.
   localparam int TIME_WIDTH = 32;
   // Width of the poll timestamp field.
   localparam int NOW_WIDTH = 32;
   localparam int DELAY_WIDTH = 16;
   localparam int SECONDS_WIDTH = 8;
   localparam int MS_PER_SECOND = 1000;
   // Width of max_trigger_seconds * 1000.
   localparam int LIMIT_WIDTH = $clog2(((1 << SECONDS_WIDTH) - 1) * MS_PER_SECOND + 1);
   localparam int CMP_WIDTH = (TIME_WIDTH > LIMIT_WIDTH) ? TIME_WIDTH : LIMIT_WIDTH;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   localparam logic ENABLE_RESET = 1'b1;
   localparam logic [DELAY_WIDTH-1:0] DELAY_RESET = '0;
   localparam logic [SECONDS_WIDTH-1:0] SECONDS_RESET = SECONDS_WIDTH'(30);

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [CMP_WIDTH-1:0] cmp_type;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      CSR_ENABLE        = 2'd0,
      CSR_TRIGGER_DELAY = 2'd1,
      CSR_MAX_SECONDS   = 2'd2
   } csr_index_type;

   // Configuration handed from the register block to the datapath.
   typedef struct packed {
      logic                   enable;
      logic [DELAY_WIDTH-1:0] trigger_delay_ms;
      logic [LIMIT_WIDTH-1:0] stuck_limit_ms;
   } csr_cfg_type;

endpackage

FILE: hdl/bodsd_chan_if.sv
// Valid/ready channel interfaces for poll samples and qualified results.
interface bodsd_req_if;
   logic                             valid;
   logic                             ready;
   logic                             left_contact;
   logic                             right_contact;
   logic [bodsd_pkg::NOW_WIDTH-1:0]  now_ms;
   logic                             system_in_error;

   modport source (output valid, left_contact, right_contact, now_ms, system_in_error,
                   input ready);
   modport sink (input valid, left_contact, right_contact, now_ms, system_in_error,
                 output ready);
endinterface

interface bodsd_rsp_if;
   logic valid;
   logic ready;
   logic left_qualified;
   logic right_qualified;
   logic obstacle;
   logic stuck_error;
   logic left_raw;
   logic right_raw;

   modport source (output valid, left_qualified, right_qualified, obstacle, stuck_error,
                   left_raw, right_raw, input ready);
   modport sink (input valid, left_qualified, right_qualified, obstacle, stuck_error,
                 left_raw, right_raw, output ready);
endinterface

FILE: hdl/bodsd_csr.sv
// APB-style configuration registers of the bumper qualifier.
module bodsd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bodsd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [bodsd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bodsd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output bodsd_pkg::csr_cfg_type              cfg
);
   import bodsd_pkg::*;

   logic                     enable_ff, enable_in;
   logic [DELAY_WIDTH-1:0]   delay_ff, delay_in;
   logic [SECONDS_WIDTH-1:0] seconds_ff, seconds_in;
   logic [LIMIT_WIDTH-1:0]   limit_ff, limit_in;
   logic                     write_en;
   csr_index_type            index;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;

   // Register writes; the stuck limit in milliseconds is computed here on a seconds write.
   always_comb begin
      enable_in  = enable_ff;
      delay_in   = delay_ff;
      seconds_in = seconds_ff;
      limit_in   = limit_ff;
      if (write_en) begin
         unique case (index)
            CSR_ENABLE: begin
               enable_in = csr_pwdata[0];
            end
            CSR_TRIGGER_DELAY: begin
               delay_in = csr_pwdata[DELAY_WIDTH-1:0];
            end
            CSR_MAX_SECONDS: begin
               seconds_in = csr_pwdata[SECONDS_WIDTH-1:0];
               limit_in   = LIMIT_WIDTH'(csr_pwdata[SECONDS_WIDTH-1:0] * MS_PER_SECOND);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= ENABLE_RESET;
         delay_ff   <= DELAY_RESET;
         seconds_ff <= SECONDS_RESET;
         limit_ff   <= LIMIT_WIDTH'(SECONDS_RESET * MS_PER_SECOND);
      end else begin
         enable_ff  <= enable_in;
         delay_ff   <= delay_in;
         seconds_ff <= seconds_in;
         limit_ff   <= limit_in;
      end
   end

   // Read data multiplexer.
   always_comb begin
      unique case (index)
         CSR_ENABLE:        csr_prdata = CSR_DATA_WIDTH'(enable_ff);
         CSR_TRIGGER_DELAY: csr_prdata = CSR_DATA_WIDTH'(delay_ff);
         CSR_MAX_SECONDS:   csr_prdata = CSR_DATA_WIDTH'(seconds_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.enable           = enable_ff;
   assign cfg.trigger_delay_ms = delay_ff;
   assign cfg.stuck_limit_ms   = limit_ff;

endmodule

FILE: hdl/bodsd_core.sv
// Input register, per-side qualification logic, state and result register.
module bodsd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  bodsd_pkg::csr_cfg_type cfg,
   bodsd_req_if.sink              req,
   bodsd_rsp_if.source            rsp
);
   import bodsd_pkg::*;

   `include "bumper_on_delay_stuck_detect_assert.svh"

   typedef struct packed {
      logic     held;
      time_type trigger_stamp;
      time_type on_time;
      logic     out_flag;
   } side_type;

   // One poll of one side: edge capture, saturating on-time and delay check.
   function automatic side_type side_step(side_type s, logic pressed, time_type now,
                                          time_type elapsed, logic [DELAY_WIDTH-1:0] delay);
      side_type          r;
      logic [TIME_WIDTH:0] sum;
      time_type          since;
      r = s;
      if (pressed) begin
         if (!s.held) begin
            r.trigger_stamp = now;
            r.on_time       = '0;
         end
         r.held    = 1'b1;
         sum       = {1'b0, r.on_time} + {1'b0, elapsed};
         r.on_time = sum[TIME_WIDTH] ? '1 : sum[TIME_WIDTH-1:0];
         since     = now - r.trigger_stamp;
         if (since >= time_type'(delay)) begin
            r.out_flag = 1'b1;
         end
      end else begin
         r.held     = 1'b0;
         r.out_flag = 1'b0;
      end
      return r;
   endfunction

   // Input register.
   logic     in_valid_ff, in_valid_in;
   logic     in_left_ff, in_right_ff, in_error_ff;
   time_type in_now_ff;

   // Result register.
   logic out_valid_ff, out_valid_in;
   logic out_lq_ff, out_rq_ff, out_obstacle_ff, out_stuck_ff, out_lraw_ff, out_rraw_ff;

   // Qualifier state.
   side_type left_ff, left_in, right_ff, right_in;
   time_type prev_stamp_ff, prev_stamp_in;

   logic     advance;
   time_type elapsed;
   side_type left_step, right_step;
   logic     left_over, right_over, stuck;
   logic     lq, rq;

   // The held sample moves on whenever the result register is free or draining.
   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_left_ff  <= req.left_contact;
         in_right_ff <= req.right_contact;
         in_error_ff <= req.system_in_error;
         in_now_ff   <= time_type'(req.now_ms);
      end
   end

   // Per-side update and stuck detection for the registered sample.
   assign elapsed    = in_now_ff - prev_stamp_ff;
   assign left_step  = side_step(left_ff, in_left_ff, in_now_ff, elapsed, cfg.trigger_delay_ms);
   assign right_step = side_step(right_ff, in_right_ff, in_now_ff, elapsed,
                                 cfg.trigger_delay_ms);
   assign left_over  = cmp_type'(left_step.on_time) > cmp_type'(cfg.stuck_limit_ms);
   assign right_over = cmp_type'(right_step.on_time) > cmp_type'(cfg.stuck_limit_ms);
   assign stuck      = cfg.enable && (left_step.held || right_step.held) &&
                       (left_over || right_over) && !in_error_ff;

   // A stuck pulse clears stamps and on-times but keeps the held and qualified flags.
   always_comb begin
      left_in       = left_ff;
      right_in      = right_ff;
      prev_stamp_in = prev_stamp_ff;
      if (advance && cfg.enable) begin
         left_in       = left_step;
         right_in      = right_step;
         prev_stamp_in = in_now_ff;
         if (stuck) begin
            left_in.trigger_stamp  = '0;
            left_in.on_time        = '0;
            right_in.trigger_stamp = '0;
            right_in.on_time       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         right_ff      <= '0;
         prev_stamp_ff <= '0;
      end else begin
         left_ff       <= left_in;
         right_ff      <= right_in;
         prev_stamp_ff <= prev_stamp_in;
      end
   end

   // Result register load.
   assign lq = cfg.enable ? left_step.out_flag : left_ff.out_flag;
   assign rq = cfg.enable ? right_step.out_flag : right_ff.out_flag;

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_lq_ff       <= lq;
         out_rq_ff       <= rq;
         out_obstacle_ff <= cfg.enable && (lq || rq);
         out_stuck_ff    <= stuck;
         out_lraw_ff     <= in_left_ff;
         out_rraw_ff     <= in_right_ff;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.left_qualified  = out_lq_ff;
   assign rsp.right_qualified = out_rq_ff;
   assign rsp.obstacle        = out_obstacle_ff;
   assign rsp.stuck_error     = out_stuck_ff;
   assign rsp.left_raw        = out_lraw_ff;
   assign rsp.right_raw       = out_rraw_ff;

   // Checks on the datapath and its state.
   `BODSD_ASSERT_NEXT(a_result_after_advance, advance, out_valid_ff)
   `BODSD_ASSERT_NEXT(a_stuck_clears_on_time, advance && stuck,
                      left_ff.on_time == '0 && right_ff.on_time == '0)
   `BODSD_ASSERT_NEXT(a_release_clears_left, advance && cfg.enable && !in_left_ff,
                      !left_ff.out_flag && !left_ff.held)
   `BODSD_ASSERT_NEXT(a_idle_keeps_stamp, !advance, $stable(prev_stamp_ff))
   `BODSD_ASSERT_SAME(a_stuck_needs_enable, stuck, cfg.enable && !in_error_ff)

endmodule

FILE: hdl/bumper_on_delay_stuck_detect.sv
// A sample moves from the input to the result register when the latter is free or draining.
// Throughput: one sample per cycle while results are taken; the input register, per-side
// add/compare logic and result register form a two-stage pipeline that a stall only holds.
// Reset: synchronous; clears all bumper state and the previous poll stamp to zero and
// restores enable = 1, trigger delay = 0 ms and maximum trigger time = 30 s.
// No clearing pass follows reset; a sample can be taken as soon as reset is released.
module bumper_on_delay_stuck_detect (
   input  logic                                clock,
   input  logic                                reset,
   bodsd_req_if.sink                           req_bus,
   bodsd_rsp_if.source                         rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bodsd_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [bodsd_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bodsd_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import bodsd_pkg::*;

   csr_cfg_type cfg;

   // Configuration registers.
   bodsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Qualification datapath.
   bodsd_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule
